// ===== sv/nsc_pkg.sv =====
// Shared types, codes and constants of the NMEA sentence checker.
`default_nettype none

package nsc_pkg;

	// Number of leading bytes searched for a message header.
	localparam int HEADER_SPAN = 8;
	// Position of the last byte of the earliest header that can complete.
	localparam int HEADER_FIRST_POS = 3;
	// Shortest sentence that can hold a checksum field.
	localparam int MIN_LENGTH = 7;
	localparam int KIND_COUNT = 6;

	localparam logic [7:0] CHAR_STAR = 8'h2A;
	localparam logic [3:0] COUNT_MAX = 4'hF;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FORMAT = 2'd1,
		ST_SUM    = 2'd2,
		ST_TYPE   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		KIND_GGA  = 3'd0,
		KIND_RMC  = 3'd1,
		KIND_ZDA  = 3'd2,
		KIND_GSV  = 3'd3,
		KIND_GSA  = 3'd4,
		KIND_UBX  = 3'd5,
		KIND_NONE = 3'd6
	} kind_t;

	// One result item, as it is packed onto the output bus.
	typedef struct packed {
		logic [7:0] received_sum;
		logic [7:0] computed_sum;
		kind_t      message_kind;
		status_t    status;
	} result_t;

	// Four-character header pattern of a message kind, first character in the top byte.
	function automatic logic [31:0] kind_pattern(input kind_t kind);
		logic [31:0] pat;
		unique case (kind)
			KIND_GGA: pat = {8'h47, 8'h47, 8'h41, 8'h2C};
			KIND_RMC: pat = {8'h52, 8'h4D, 8'h43, 8'h2C};
			KIND_ZDA: pat = {8'h5A, 8'h44, 8'h41, 8'h2C};
			KIND_GSV: pat = {8'h47, 8'h53, 8'h56, 8'h2C};
			KIND_GSA: pat = {8'h47, 8'h53, 8'h41, 8'h2C};
			KIND_UBX: pat = {8'h55, 8'h42, 8'h58, 8'h2C};
			default:  pat = 32'h0;
		endcase
		return pat;
	endfunction

	// Value of one hex digit; anything that is not a hex digit counts as zero.
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h37);
		end else begin
			v = 4'h0;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== sv/nmea_sentence_checker.sv =====
// Top level of the NMEA sentence checker: input register, sentence state and result register.
`default_nettype none

// The block takes one sentence byte per item, from the leading dollar sign through the
// trailing checksum and line end, with s_tlast on the final byte. It accepts one item in
// every clock cycle while no final byte waits on a stalled result; each byte passes an
// input register and, when it is the final byte of a sentence, then the result register,
// from which its verdict is offered. Only the final byte of a sentence produces a result
// item; all other bytes only update the running XOR, the byte count, the five-byte tail
// window, the NUL flag and the header hits, and every final byte returns that state to
// zero. A stalled result holds back only a final byte: other bytes keep flowing, and
// s_tready drops once a final byte waits in the input register behind a result that has
// not been taken.
module nmea_sentence_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata    // [1:0] status, [4:2] message_kind,
	                                    // [12:5] computed_sum, [20:13] received_sum,
	                                    // [23:21] zero
);

	localparam int KC = nsc_pkg::KIND_COUNT;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Sentence state.
	logic [7:0]    xor_q;
	logic [3:0]    count_q;
	logic [7:0]    tail_q [5];
	logic [KC-1:0] hits_q;
	logic          nul_q;

	// Result register.
	logic               out_valid_q;
	nsc_pkg::result_t   out_q;

	logic out_ready;
	logic adv;

	logic [7:0]    xor_n;
	logic [3:0]    count_n;
	logic [7:0]    tail_n [5];
	logic [KC-1:0] hits_n;
	logic [KC-1:0] match;
	logic          nul_n;
	logic          in_header;
	nsc_pkg::result_t res;

	// Only a final byte needs room in the result register.
	assign out_ready = !out_valid_q || m_tready;
	assign adv       = valid_s1 && (!last_s1 || out_ready);
	assign s_tready  = !valid_s1 || !last_s1 || out_ready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {3'b000, out_q};

	// Header comparison on the four newest bytes after this one is shifted in.
	nsc_hdr_match u_hdr (
		.window ({tail_q[2], tail_q[3], tail_q[4], byte_s1}),
		.hits   (match)
	);

	// Next sentence state for the byte in the input register.
	always_comb begin
		xor_n   = (count_q != 4'h0) ? (xor_q ^ byte_s1) : xor_q;
		count_n = (count_q != nsc_pkg::COUNT_MAX) ? 4'(count_q + 4'h1) : count_q;
		for (int i = 0; i < 4; i++) begin
			tail_n[i] = tail_q[i+1];
		end
		tail_n[4] = byte_s1;

		in_header = ({1'b0, count_q} < 5'(nsc_pkg::HEADER_SPAN));
		nul_n     = nul_q;
		hits_n    = hits_q;
		if (in_header) begin
			nul_n = nul_q || (byte_s1 == 8'h00);
			if ((count_q >= 4'(nsc_pkg::HEADER_FIRST_POS)) && !nul_n) begin
				hits_n = hits_q | match;
			end
		end
	end

	// Verdict for a final byte.
	always_comb begin
		priority if (hits_n[nsc_pkg::KIND_GGA]) res.message_kind = nsc_pkg::KIND_GGA;
		else if (hits_n[nsc_pkg::KIND_RMC])     res.message_kind = nsc_pkg::KIND_RMC;
		else if (hits_n[nsc_pkg::KIND_ZDA])     res.message_kind = nsc_pkg::KIND_ZDA;
		else if (hits_n[nsc_pkg::KIND_GSV])     res.message_kind = nsc_pkg::KIND_GSV;
		else if (hits_n[nsc_pkg::KIND_GSA])     res.message_kind = nsc_pkg::KIND_GSA;
		else if (hits_n[nsc_pkg::KIND_UBX])     res.message_kind = nsc_pkg::KIND_UBX;
		else                                    res.message_kind = nsc_pkg::KIND_NONE;

		if ((count_n < 4'(nsc_pkg::MIN_LENGTH)) || (tail_n[0] != nsc_pkg::CHAR_STAR)) begin
			res.status       = nsc_pkg::ST_FORMAT;
			res.computed_sum = 8'h00;
			res.received_sum = 8'h00;
		end else begin
			// The star, the checksum field and the two bytes after it were folded into the XOR; take them out again.
			res.computed_sum = xor_n ^ tail_n[0] ^ tail_n[1] ^ tail_n[2] ^ tail_n[3]
			                   ^ tail_n[4];
			res.received_sum = {nsc_pkg::hex_value(tail_n[1]), nsc_pkg::hex_value(tail_n[2])};
			priority if (res.computed_sum != res.received_sum) begin
				res.status = nsc_pkg::ST_SUM;
			end else if (res.message_kind == nsc_pkg::KIND_NONE) begin
				res.status = nsc_pkg::ST_TYPE;
			end else begin
				res.status = nsc_pkg::ST_OK;
			end
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Sentence state; a final byte returns it to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q   <= 8'h00;
			count_q <= 4'h0;
			hits_q  <= '0;
			nul_q   <= 1'b0;
			for (int i = 0; i < 5; i++) begin
				tail_q[i] <= 8'h00;
			end
		end else if (adv) begin
			if (last_s1) begin
				xor_q   <= 8'h00;
				count_q <= 4'h0;
				hits_q  <= '0;
				nul_q   <= 1'b0;
				for (int i = 0; i < 5; i++) begin
					tail_q[i] <= 8'h00;
				end
			end else begin
				xor_q   <= xor_n;
				count_q <= count_n;
				hits_q  <= hits_n;
				nul_q   <= nul_n;
				for (int i = 0; i < 5; i++) begin
					tail_q[i] <= tail_n[i];
				end
			end
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== sv/nsc_hdr_match.sv =====
// Compares the four newest bytes against every known message header.
`default_nettype none

module nsc_hdr_match (
	input  wire logic [31:0]                     window,  // oldest byte in the top bits
	output logic      [nsc_pkg::KIND_COUNT-1:0]  hits
);

	// One comparator per message kind.
	always_comb begin
		for (int k = 0; k < nsc_pkg::KIND_COUNT; k++) begin
			hits[k] = (window == nsc_pkg::kind_pattern(nsc_pkg::kind_t'(3'(k))));
		end
	end

endmodule

`default_nettype wire

// ===== sv/nsc_checker.sv =====
// Port-level assertions for the NMEA sentence checker and their binding to the top level.
`default_nettype none

module nsc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata
);

	// A stalled result item keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A format failure reports no sums, and the padding bits stay zero.
	a_format: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == nsc_pkg::ST_FORMAT) |->
			(m_tdata[20:5] == 16'h0000) && (m_tdata[23:21] == 3'b000))
		else $error("format failure carries sums");

	// An accepted sentence has matching sums and a known kind.
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == nsc_pkg::ST_OK) |->
			(m_tdata[12:5] == m_tdata[20:13]) && (m_tdata[4:2] != nsc_pkg::KIND_NONE))
		else $error("accepted sentence with bad sum or no kind");

	// An unknown-type verdict only follows a good checksum and no kind found.
	a_type: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == nsc_pkg::ST_TYPE) |->
			(m_tdata[4:2] == nsc_pkg::KIND_NONE) && (m_tdata[12:5] == m_tdata[20:13]))
		else $error("unknown-type verdict inconsistent");

	// A result can only appear after a final byte was accepted and passed the input register.
	a_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
		else $error("result without a final byte");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (.*);

`default_nettype wire
